### rtl/plhm_pkg.sv
// Package for the pixel label lookup with horizon masking.
// Holds defaults, register map codes and command codes.
// Used by plhm_label_ram and pixel_lut_labeller_horizon_mask.
package plhm_pkg;

  localparam int CHANNEL_INDEX_BITS_DEF = 6;
  localparam int COORD_BITS_DEF         = 12;
  localparam int CHANNEL_BITS           = 8;
  localparam int LABEL_BITS             = 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_MASK_EN      = 3'd0;
  localparam logic [2:0] REG_HORIZON_LEFT = 3'd1;
  localparam logic [2:0] REG_HORIZON_RGHT = 3'd2;
  localparam logic [2:0] REG_IMG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_IMG_HEIGHT   = 3'd4;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_WRITE    = 1'b1;

endpackage

### rtl/plhm_label_ram.sv
// Single-port label table RAM with registered read data.
// Depends on plhm_pkg for the address and label width defaults.
module plhm_label_ram
  import plhm_pkg::*;
#(
  parameter int ADDR_W = 3 * CHANNEL_INDEX_BITS_DEF,
  parameter int DATA_W = LABEL_BITS
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read data holds while the consuming stage is stalled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pixel_lut_labeller_horizon_mask.sv
// Top level: pixel classifier by label table lookup with horizon masking.
// Depends on plhm_pkg and plhm_label_ram.
//
// Channel | Dir | Signals                    | Contents
// in      | in  | in_tvalid/tready/tdata/tuser | pixel or table write item
// out     | out | out_tvalid/tready/tdata/tuser | label and masked flag
// cfg     | in  | cfg_psel..cfg_pready        | APB registers at 4*index
//
// One item enters per cycle while in_tready is high; a classify result passes
// the input register, horizon math, multiply and table read, and compare stages.
// Reset is synchronous and active low and clears the valid bits and config registers.
// The label table is not cleared; every stage holds while the stage after it
// is full and stalled, so bubbles are squeezed out before input is refused.
module pixel_lut_labeller_horizon_mask
  import plhm_pkg::*;
#(
  parameter int CHANNEL_INDEX_BITS = CHANNEL_INDEX_BITS_DEF,
  parameter int COORD_BITS         = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // column, row, chan_first, chan_second, chan_third, table_index,
  // table_value, zero padding
  input  logic [((2*COORD_BITS + 3*CHANNEL_BITS + 3*CHANNEL_INDEX_BITS
                  + LABEL_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                  in_tuser,     // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [LABEL_BITS-1:0] out_tdata,    // label
  output logic                  out_tuser,    // masked
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int REG_W   = COORD_BITS + 1;
  localparam int DIFF_W  = REG_W + 1;
  localparam int PROD_W  = 2 * REG_W;
  localparam int TAB_AW  = 3 * CHANNEL_INDEX_BITS;
  localparam int OFF_ROW = COORD_BITS;
  localparam int OFF_C1  = 2 * COORD_BITS;
  localparam int OFF_C2  = OFF_C1 + CHANNEL_BITS;
  localparam int OFF_C3  = OFF_C2 + CHANNEL_BITS;
  localparam int OFF_IDX = OFF_C3 + CHANNEL_BITS;
  localparam int OFF_VAL = OFF_IDX + TAB_AW;

  // ---------------- configuration registers ----------------
  logic                    mask_en_r;
  logic signed [REG_W-1:0] hor_left_r;
  logic signed [REG_W-1:0] hor_right_r;
  logic [REG_W-1:0]        width_r;
  logic [REG_W-1:0]        height_r;
  logic                    cfg_wr;
  logic [2:0]              cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_en_r   <= 1'b0;
      hor_left_r  <= '0;
      hor_right_r <= '0;
      width_r     <= REG_W'(WIDTH_RESET);
      height_r    <= REG_W'(HEIGHT_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MASK_EN:      mask_en_r   <= cfg_pwdata[0];
        REG_HORIZON_LEFT: hor_left_r  <= cfg_pwdata[REG_W-1:0];
        REG_HORIZON_RGHT: hor_right_r <= cfg_pwdata[REG_W-1:0];
        REG_IMG_WIDTH:    width_r     <= cfg_pwdata[REG_W-1:0];
        REG_IMG_HEIGHT:   height_r    <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MASK_EN:      cfg_prdata = CFG_DATA_W'(mask_en_r);
      REG_HORIZON_LEFT: cfg_prdata = CFG_DATA_W'(unsigned'(hor_left_r));
      REG_HORIZON_RGHT: cfg_prdata = CFG_DATA_W'(unsigned'(hor_right_r));
      REG_IMG_WIDTH:    cfg_prdata = CFG_DATA_W'(width_r);
      REG_IMG_HEIGHT:   cfg_prdata = CFG_DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // ---------------- stage enables ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic en_s1, en_s2, en_s3, en_out;

  assign en_out    = !out_valid_r || out_tready;
  assign en_s3     = !s3_valid_r || en_out;
  assign en_s2     = !s2_valid_r || en_s3;
  assign en_s1     = !s1_valid_r || en_s2;
  assign in_tready = en_s1;

  // ---------------- stage 1: input register ----------------
  logic                    s1_cmd_r;
  logic [COORD_BITS-1:0]   s1_col_r;
  logic [COORD_BITS-1:0]   s1_row_r;
  logic [CHANNEL_BITS-1:0] s1_c1_r, s1_c2_r, s1_c3_r;
  logic [TAB_AW-1:0]       s1_idx_r;
  logic [LABEL_BITS-1:0]   s1_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en_s1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_cmd_r <= in_tuser;
      s1_col_r <= in_tdata[COORD_BITS-1:0];
      s1_row_r <= in_tdata[OFF_ROW +: COORD_BITS];
      s1_c1_r  <= in_tdata[OFF_C1 +: CHANNEL_BITS];
      s1_c2_r  <= in_tdata[OFF_C2 +: CHANNEL_BITS];
      s1_c3_r  <= in_tdata[OFF_C3 +: CHANNEL_BITS];
      s1_idx_r <= in_tdata[OFF_IDX +: TAB_AW];
      s1_val_r <= in_tdata[OFF_VAL +: LABEL_BITS];
    end
  end

  // ---------------- stage 2: bounds and horizon distances ----------------
  logic signed [DIFF_W-1:0] row_s, left_s, right_s, hi_s, lo_s;
  logic signed [DIFF_W-1:0] num_d, den_d, num_neg, den_neg;
  logic [REG_W-1:0]         num_abs, den_abs;
  logic                     outside, above, in_band, dir_up, keep;
  logic [TAB_AW-1:0]        pix_addr;

  always_comb begin
    row_s   = signed'({2'b00, s1_row_r});
    left_s  = {hor_left_r[REG_W-1], hor_left_r};
    right_s = {hor_right_r[REG_W-1], hor_right_r};
    dir_up  = right_s > left_s;
    hi_s    = dir_up ? right_s : left_s;
    lo_s    = dir_up ? left_s : right_s;
    num_d   = row_s - left_s;
    den_d   = right_s - left_s;
    num_neg = -num_d;
    den_neg = -den_d;
    num_abs = num_d[DIFF_W-1] ? num_neg[REG_W-1:0] : num_d[REG_W-1:0];
    den_abs = den_d[DIFF_W-1] ? den_neg[REG_W-1:0] : den_d[REG_W-1:0];
    outside = ({1'b0, s1_col_r} >= width_r) || ({1'b0, s1_row_r} >= height_r);
    above   = mask_en_r && (row_s > hi_s);
    // Equal ends leave the row unmasked.
    in_band = mask_en_r && (row_s >= lo_s) && (hor_left_r != hor_right_r);
    keep    = (s1_cmd_r == CMD_WRITE) || (!outside && !above);
    pix_addr = {s1_c1_r[CHANNEL_BITS-1 -: CHANNEL_INDEX_BITS],
                s1_c2_r[CHANNEL_BITS-1 -: CHANNEL_INDEX_BITS],
                s1_c3_r[CHANNEL_BITS-1 -: CHANNEL_INDEX_BITS]};
  end

  logic                  s2_cmd_r;
  logic [TAB_AW-1:0]     s2_addr_r;
  logic [LABEL_BITS-1:0] s2_val_r;
  logic                  s2_band_r, s2_up_r;
  logic [REG_W-1:0]      s2_opa_r, s2_num_r, s2_den_r, s2_wm1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en_s2) begin
      s2_valid_r <= s1_valid_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_addr_r <= (s1_cmd_r == CMD_WRITE) ? s1_idx_r : pix_addr;
      s2_val_r  <= s1_val_r;
      s2_band_r <= in_band;
      s2_up_r   <= dir_up;
      // Rising line: masked when (x+1)*den <= num*(w-1); falling: x*den > num*(w-1).
      s2_opa_r  <= {1'b0, s1_col_r} + REG_W'(dir_up);
      s2_num_r  <= num_abs;
      s2_den_r  <= den_abs;
      s2_wm1_r  <= width_r - REG_W'(1);
    end
  end

  // ---------------- stage 3: products and table access ----------------
  logic                  ram_we, ram_re;
  logic [LABEL_BITS-1:0] ram_rdata;

  assign ram_we = en_s3 && s2_valid_r && (s2_cmd_r == CMD_WRITE);
  assign ram_re = en_s3 && s2_valid_r && (s2_cmd_r == CMD_CLASSIFY);

  plhm_label_ram #(
    .ADDR_W (TAB_AW),
    .DATA_W (LABEL_BITS)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (s2_addr_r),
    .wdata (s2_val_r),
    .rdata (ram_rdata)
  );

  logic              s3_band_r, s3_up_r;
  logic [PROD_W-1:0] s3_pa_r, s3_pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en_s3) begin
      s3_valid_r <= s2_valid_r && (s2_cmd_r == CMD_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      s3_band_r <= s2_band_r;
      s3_up_r   <= s2_up_r;
      s3_pa_r   <= PROD_W'(s2_opa_r) * PROD_W'(s2_den_r);
      s3_pb_r   <= PROD_W'(s2_num_r) * PROD_W'(s2_wm1_r);
    end
  end

  // ---------------- output stage ----------------
  logic                  masked;
  logic [LABEL_BITS-1:0] out_label_r;
  logic                  out_masked_r;

  assign masked = s3_band_r && (s3_up_r ? (s3_pa_r <= s3_pb_r) : (s3_pa_r > s3_pb_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_label_r  <= masked ? '0 : ram_rdata;
      out_masked_r <= masked;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_label_r;
  assign out_tuser  = out_masked_r;

`ifndef SYNTHESIS
  a_masked_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_masked_r |-> mask_en_r && out_label_r == '0)
    else $error("masked result while horizon masking is off");

  a_s3_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !en_out |=> s3_valid_r)
    else $error("stage 3 item lost during stall");

  a_write_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    en_s3 && s2_valid_r && (s2_cmd_r == CMD_WRITE) |=> !s3_valid_r)
    else $error("table write item reached the result stage");
`endif

endmodule
